// File: design/ccrc_pkg.sv
// shared types, constants and a helper function for the crc engine
package ccrc_pkg;

    localparam int CRC_W  = 32;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    // register map, word index into the apb window
    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH_SEL = 3'd0,
        REG_POLY      = 3'd1,
        REG_REFLECTED = 3'd2,
        REG_INIT      = 3'd3,
        REG_FINAL_XOR = 3'd4
    } reg_idx_t;

    // crc width codes, code three behaves as 32 bits
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;

    localparam logic [1:0]       RST_WIDTH_SEL = WIDTH_32;
    localparam logic [CRC_W-1:0] RST_POLY      = 32'h04C1_1DB7;
    localparam logic             RST_REFLECTED = 1'b1;
    localparam logic [CRC_W-1:0] RST_INIT      = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] RST_FINAL_XOR = 32'hFFFF_FFFF;

    // decoded settings handed from the register block to the datapath
    typedef struct packed {
        logic             restart;
        logic             reflected;
        logic [1:0]       width_sel;
        logic [4:0]       align_shift;
        logic [CRC_W-1:0] mask;
        logic [CRC_W-1:0] poly_norm;
        logic [CRC_W-1:0] poly_refl;
        logic [CRC_W-1:0] init_masked;
        logic [CRC_W-1:0] final_xor;
    } cfg_t;

    function automatic logic [CRC_W-1:0] reverse32(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++)
        begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

endpackage

// File: design/ccrc_cfg_regs.sv
// apb configuration registers and decoded crc settings
module ccrc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ccrc_pkg::CRC_W-1:0]    pwdata,
    output logic [ccrc_pkg::CRC_W-1:0]    prdata,
    output logic                          pready,
    output ccrc_pkg::cfg_t                cfg
);
    import ccrc_pkg::*;

    logic [1:0]       width_sel_reg, width_sel_next;
    logic [CRC_W-1:0] poly_reg, poly_next;
    logic             reflected_reg, reflected_next;
    logic [CRC_W-1:0] init_reg, init_next;
    logic [CRC_W-1:0] fxor_reg, fxor_next;
    logic             restart_reg, restart_next;
    logic             wr_en;
    reg_idx_t         idx;
    logic [CRC_W-1:0] poly_masked;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        width_sel_next = width_sel_reg;
        poly_next      = poly_reg;
        reflected_next = reflected_reg;
        init_next      = init_reg;
        fxor_next      = fxor_reg;
        restart_next   = 1'b0;
        if (wr_en)
        begin
            restart_next = 1'b1;
            case (idx)
                REG_WIDTH_SEL: width_sel_next = pwdata[1:0];
                REG_POLY:      poly_next      = pwdata;
                REG_REFLECTED: reflected_next = pwdata[0];
                REG_INIT:      init_next      = pwdata;
                REG_FINAL_XOR: fxor_next      = pwdata;
                default:       restart_next   = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_sel_reg <= RST_WIDTH_SEL;
            poly_reg      <= RST_POLY;
            reflected_reg <= RST_REFLECTED;
            init_reg      <= RST_INIT;
            fxor_reg      <= RST_FINAL_XOR;
            restart_reg   <= 1'b0;
        end
        else
        begin
            width_sel_reg <= width_sel_next;
            poly_reg      <= poly_next;
            reflected_reg <= reflected_next;
            init_reg      <= init_next;
            fxor_reg      <= fxor_next;
            restart_reg   <= restart_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_WIDTH_SEL: prdata = {{(CRC_W-2){1'b0}}, width_sel_reg};
            REG_POLY:      prdata = poly_reg;
            REG_REFLECTED: prdata = {{(CRC_W-1){1'b0}}, reflected_reg};
            REG_INIT:      prdata = init_reg;
            REG_FINAL_XOR: prdata = fxor_reg;
            default:       prdata = '0;
        endcase
    end

    // mask and alignment per width
    always_comb
    begin
        case (width_sel_reg)
            WIDTH_8:
            begin
                cfg.mask        = 32'h0000_00FF;
                cfg.align_shift = 5'd24;
            end
            WIDTH_16:
            begin
                cfg.mask        = 32'h0000_FFFF;
                cfg.align_shift = 5'd16;
            end
            default:
            begin
                cfg.mask        = 32'hFFFF_FFFF;
                cfg.align_shift = 5'd0;
            end
        endcase
        poly_masked     = poly_reg & cfg.mask;
        cfg.restart     = restart_reg;
        cfg.reflected   = reflected_reg;
        cfg.width_sel   = width_sel_reg;
        cfg.poly_norm   = poly_masked << cfg.align_shift;
        cfg.poly_refl   = reverse32(poly_masked) >> cfg.align_shift;
        cfg.init_masked = init_reg & cfg.mask;
        cfg.final_xor   = fxor_reg;
    end

endmodule

// File: design/ccrc_byte_update.sv
// eight crc bit steps for one byte, normal or reflected order
module ccrc_byte_update (
    input  ccrc_pkg::cfg_t                cfg,
    input  logic [ccrc_pkg::CRC_W-1:0]    crc_in,
    input  logic [ccrc_pkg::BYTE_W-1:0]   data_byte,
    output logic [ccrc_pkg::CRC_W-1:0]    crc_out
);
    import ccrc_pkg::*;

    logic [CRC_W-1:0] acc;

    // normal order works left aligned in 32 bits so the top bit is always bit 31
    always_comb
    begin
        if (cfg.reflected)
        begin
            acc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
            for (int i = 0; i < BYTE_W; i++)
            begin
                acc = acc[0] ? ((acc >> 1) ^ cfg.poly_refl) : (acc >> 1);
            end
            crc_out = acc & cfg.mask;
        end
        else
        begin
            acc = (crc_in << cfg.align_shift) ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
            for (int i = 0; i < BYTE_W; i++)
            begin
                acc = acc[CRC_W-1] ? ((acc << 1) ^ cfg.poly_norm) : (acc << 1);
            end
            crc_out = (acc >> cfg.align_shift) & cfg.mask;
        end
    end

endmodule

// File: design/configurable_crc_engine_core.sv
// top level of the configurable byte-stream crc engine
//
// Byte-serial CRC engine for 8, 16 or 32 bit CRCs with programmable polynomial,
// init value, final xor and bit order (normal or reflected, input and output
// alike). One byte request is taken every clock while no last byte waits: an
// input stage register holds the byte, eight unrolled polynomial steps update
// the crc register in the next cycle, and on the byte marked with s_tlast the
// result (crc xor final_xor, masked to the width, upper bits zero) is loaded
// into the output register and the crc register reloads init_value. Throughput
// is one byte per cycle while no last byte waits, limited by the feedback loop
// through the crc register. Only a last byte waits while an earlier result is
// still unclaimed on the output side; other bytes keep flowing. Any write to a
// listed register sets a registered restart flag that then reloads the crc
// register from init_value under the new settings; program only while the
// stream is idle.
// Register map (apb, word aligned): 0x00 width_select (0: 8, 1: 16, else 32),
// 0x04 polynomial (normal form), 0x08 reflected, 0x0C init_value, 0x10 final_xor.
module configurable_crc_engine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ccrc_pkg::CRC_W-1:0]    pwdata,
    output logic [ccrc_pkg::CRC_W-1:0]    prdata,
    output logic                          pready,
    // byte input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ccrc_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // last_byte
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ccrc_pkg::CRC_W-1:0]    m_tdata    // [31:0] crc_value
);
    import ccrc_pkg::*;

    cfg_t              cfg;
    logic              stage_valid_reg, stage_valid_next;
    logic [BYTE_W-1:0] stage_byte_reg, stage_byte_next;
    logic              stage_last_reg, stage_last_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic              out_valid_reg, out_valid_next;
    logic [CRC_W-1:0]  out_crc_reg, out_crc_next;
    logic [CRC_W-1:0]  crc_upd;
    logic              stage_fire;
    logic              in_fire;

    ccrc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccrc_byte_update u_upd (
        .cfg       (cfg),
        .crc_in    (crc_reg),
        .data_byte (stage_byte_reg),
        .crc_out   (crc_upd)
    );

    // a last byte needs a free output slot, ordinary bytes always proceed
    assign stage_fire = stage_valid_reg & (~stage_last_reg | ~out_valid_reg | m_tready);
    assign s_tready   = ~stage_valid_reg | stage_fire;
    assign in_fire    = s_tvalid & s_tready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_byte_next  = stage_byte_reg;
        stage_last_next  = stage_last_reg;
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
            stage_byte_next  = s_tdata;
            stage_last_next  = s_tlast;
        end
        else if (stage_fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // crc register: config restart, end of message reload, or byte update
    always_comb
    begin
        crc_next = crc_reg;
        if (cfg.restart)
        begin
            crc_next = cfg.init_masked;
        end
        else if (stage_fire)
        begin
            crc_next = stage_last_reg ? cfg.init_masked : crc_upd;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_crc_next   = out_crc_reg;
        if (stage_fire && stage_last_reg)
        begin
            out_valid_next = 1'b1;
            out_crc_next   = (crc_upd ^ cfg.final_xor) & cfg.mask;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            stage_last_reg  <= 1'b0;
            crc_reg         <= RST_INIT;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            stage_last_reg  <= stage_last_next;
            crc_reg         <= crc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        stage_byte_reg <= stage_byte_next;
        out_crc_reg    <= out_crc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;

    // input side only stalls when the stage holds a byte
    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> stage_valid_reg)
        else $error("input stalled with empty stage");

    // crc register reloads init after a message end
    a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && stage_last_reg && !cfg.restart) |=> (crc_reg == cfg.init_masked))
        else $error("crc register not reloaded after last byte");

    // a new result only follows a last byte leaving the stage
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(stage_fire && stage_last_reg))
        else $error("result appeared without a last byte");

    // result bits above the selected width stay clear
    a_result_masked: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata & ~cfg.mask) == '0))
        else $error("result has bits above the crc width");

endmodule

// File: sim/tb_configurable_crc_engine_core.sv
// self-checking testbench for the configurable crc engine top level
module tb_configurable_crc_engine_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ccrc_pkg::*;

    // width code three is an alias of the 32 bit width
    localparam logic [1:0]       WIDTH_ALIAS_32 = 2'd3;
    // first word index past the register map, writes there must be ignored
    localparam logic [IDX_W-1:0] IDX_UNUSED     = 3'd5;

    // ------------------------------------------------------------------
    // crc predictor and result store
    // ------------------------------------------------------------------
    class crc_scoreboard;
        logic [1:0]       width_code;
        logic [CRC_W-1:0] poly_norm;
        logic             bit_reflect;
        logic [CRC_W-1:0] init_word;
        logic [CRC_W-1:0] xor_word;
        logic [CRC_W-1:0] crc_state;
        logic [CRC_W-1:0] expected_crcs[$];
        int               errors;

        function new();
            width_code  = RST_WIDTH_SEL;
            poly_norm   = RST_POLY;
            bit_reflect = RST_REFLECTED;
            init_word   = RST_INIT;
            xor_word    = RST_FINAL_XOR;
            errors      = 0;
            reload();
        endfunction

        function int crc_bits();
            case (width_code)
                WIDTH_8:  return 8;
                WIDTH_16: return 16;
                default:  return 32;
            endcase
        endfunction

        function logic [CRC_W-1:0] width_mask();
            case (width_code)
                WIDTH_8:  return 32'h0000_00FF;
                WIDTH_16: return 32'h0000_FFFF;
                default:  return 32'hFFFF_FFFF;
            endcase
        endfunction

        // start of a new message under the current settings
        function void reload();
            crc_state = init_word & width_mask();
        endfunction

        // mirror of a register write, unlisted indexes leave the message alone
        function void write_reg(logic [IDX_W-1:0] idx, logic [CRC_W-1:0] val);
            case (idx)
                REG_WIDTH_SEL: width_code  = val[1:0];
                REG_POLY:      poly_norm   = val;
                REG_REFLECTED: bit_reflect = val[0];
                REG_INIT:      init_word   = val;
                REG_FINAL_XOR: xor_word    = val;
                default:       return;
            endcase
            reload();
        endfunction

        function logic [CRC_W-1:0] reg_value(logic [IDX_W-1:0] idx);
            case (idx)
                REG_WIDTH_SEL: return {30'd0, width_code};
                REG_POLY:      return poly_norm;
                REG_REFLECTED: return {31'd0, bit_reflect};
                REG_INIT:      return init_word;
                default:       return xor_word;
            endcase
        endfunction

        // one accepted byte request: eight polynomial steps, result on last
        function void note_byte(logic [7:0] data, logic last_flag);
            int               w;
            logic [CRC_W-1:0] m;
            logic [CRC_W-1:0] p;
            logic [CRC_W-1:0] rp;
            logic [CRC_W-1:0] r;
            w  = crc_bits();
            m  = width_mask();
            p  = poly_norm & m;
            r  = crc_state & m;
            rp = '0;
            if (bit_reflect)
            begin
                // polynomial mirrored within the active width
                for (int i = 0; i < w; i++)
                    if (p[i])
                        rp[w-1-i] = 1'b1;
                r ^= {24'd0, data};
                for (int k = 0; k < 8; k++)
                    r = r[0] ? ((r >> 1) ^ rp) : (r >> 1);
            end
            else
            begin
                r ^= {24'd0, data} << (w - 8);
                for (int k = 0; k < 8; k++)
                    r = r[w-1] ? (((r << 1) ^ p) & m) : ((r << 1) & m);
            end
            crc_state = r & m;
            if (last_flag)
            begin
                expected_crcs.push_back((crc_state ^ xor_word) & m);
                reload();
            end
        endfunction

        function void mismatch(string what, logic [CRC_W-1:0] exp_v,
                               logic [CRC_W-1:0] act_v);
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, what, exp_v, act_v);
            errors++;
        endfunction

        function void check_crc(logic [CRC_W-1:0] actual);
            logic [CRC_W-1:0] exp_v;
            if (expected_crcs.size() == 0)
            begin
                $display("%0t ns: unexpected crc result, expected none, actual %h",
                         $time, actual);
                errors++;
                return;
            end
            exp_v = expected_crcs.pop_front();
            if (actual !== exp_v)
                mismatch("crc_value", exp_v, actual);
        endfunction

        function int pending();
            return expected_crcs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // dut and stimulus signals
    // ------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [CRC_W-1:0]    pwdata;
    logic [CRC_W-1:0]    prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata;   // [7:0] data_byte
    logic                s_tlast;   // last_byte
    logic                m_tvalid;
    logic                m_tready;
    logic [CRC_W-1:0]    m_tdata;   // [31:0] crc_value

    crc_scoreboard board;
    int            src_idle_pct;
    int            snk_idle_pct;

    configurable_crc_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // byte request driver
    // ------------------------------------------------------------------
    // valid stays high between back-to-back requests, it only drops for a gap
    task automatic push_byte(input logic [7:0] data, input logic last_flag);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last_flag;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_byte(data, last_flag);
    endtask

    // drop valid, let every result drain and the pipeline empty out
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() > 0)
            @(posedge clk);
        // covers the input stage and the result register
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // apb access
    // ------------------------------------------------------------------
    task automatic apb_access(input logic [IDX_W-1:0] idx, input logic wr,
                              input logic [CRC_W-1:0] wdata,
                              output logic [CRC_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // write a register, then read it back if it is a listed one
    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
        logic [CRC_W-1:0] rd;
        apb_access(idx, 1'b1, val, rd);
        board.write_reg(idx, val);
        if (idx < IDX_UNUSED)
        begin
            apb_access(idx, 1'b0, '0, rd);
            if (rd !== board.reg_value(idx))
                board.mismatch("prdata", board.reg_value(idx), rd);
        end
    endtask

    task automatic program_all(input logic [1:0] w, input logic [CRC_W-1:0] p,
                               input logic rf, input logic [CRC_W-1:0] iv,
                               input logic [CRC_W-1:0] xv);
        quiesce();
        reg_write(REG_WIDTH_SEL, {30'd0, w});
        reg_write(REG_POLY, p);
        reg_write(REG_REFLECTED, {31'd0, rf});
        reg_write(REG_INIT, iv);
        reg_write(REG_FINAL_XOR, xv);
    endtask

    // 32 bit word that is an extreme a quarter of the time
    function automatic logic [CRC_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CRC_W-1:0] pick_poly();
        case ($urandom_range(15))
            0:       return 32'h0000_0007;
            1:       return 32'h0000_0031;
            2:       return 32'h0000_1021;
            3:       return 32'h0000_8005;
            4:       return 32'h0000_3D65;
            5:       return 32'h04C1_1DB7;
            6:       return 32'h0000_0000;
            7:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result sink: random backpressure, every accepted result is checked
    // ------------------------------------------------------------------
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_crc(m_tdata);
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int   sent;
        int   phase_bytes;
        int   msg_len;
        bit   cut_short;
        logic lst;

        board        = new();
        src_idle_pct = 12;
        snk_idle_pct = 72;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tlast      <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, single-byte messages at both byte extremes
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);

        // a register write in mid-message drops the partial crc
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
        program_all(WIDTH_8, 32'h0000_0007, 1'b0, 32'h0, 32'h0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);

        // a write past the register map leaves the message running
        program_all(WIDTH_16, 32'h0000_1021, 1'b0, 32'h0000_FFFF, 32'h0);
        push_byte(8'h01, 1'b0);
        quiesce();
        reg_write(IDX_UNUSED, 32'hFFFF_FFFF);
        push_byte(8'h80, 1'b1);

        // width code three acts as 32 bits
        program_all(WIDTH_ALIAS_32, 32'h0000_8005, 1'b1, 32'h0, 32'hFFFF_FFFF);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);

        // reflected 8 and 16 bit variants
        program_all(WIDTH_8, 32'h0000_0031, 1'b1, 32'h0, 32'h0);
        push_byte(8'h31, 1'b0);
        push_byte(8'h32, 1'b0);
        push_byte(8'h33, 1'b1);
        program_all(WIDTH_16, 32'h0000_3D65, 1'b1, 32'h0, 32'h0000_FFFF);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b1);

        // polynomial and init extremes, normal 32 bit order
        program_all(WIDTH_32, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 32'h0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b1);
        program_all(WIDTH_32, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'hFFFF_FFFF);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);

        // random part: settings change between phases, messages mostly short
        sent = 0;
        while (sent < 1530)
        begin
            if (sent < 510)
            begin
                src_idle_pct = 12;
                snk_idle_pct = 72;
            end
            else if (sent < 1020)
            begin
                src_idle_pct = 72;
                snk_idle_pct = 12;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            program_all(2'($urandom_range(3)), pick_poly(), 1'($urandom_range(1)),
                        pick_word(), pick_word());
            phase_bytes = 0;
            while (phase_bytes < 48)
            begin
                msg_len   = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                                     : $urandom_range(12, 1);
                cut_short = ($urandom_range(14) == 0);
                for (int i = 0; i < msg_len; i++)
                begin
                    lst = (i == msg_len - 1) && !cut_short;
                    push_byte(8'($urandom), lst);
                end
                phase_bytes += msg_len;
                if (cut_short)
                begin
                    // idle in mid-message, then either restart or ignored write
                    quiesce();
                    if ($urandom_range(1))
                        reg_write(IDX_W'($urandom_range(7, 5)), $urandom);
                    else
                        reg_write(REG_INIT, pick_word());
                end
            end
            sent += phase_bytes;
        end

        quiesce();
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
